@@ rtl/ldpr_pkg.sv @@
`timescale 1ns / 1ps

package ldpr_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W      = 32;
    localparam int OFFSET_W    = 5;
    localparam int FRAME_OUT_W = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_MODULUS = 8'd1;

    // Reset values of the configuration registers
    localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 5'd12;
    localparam logic [ADDR_W-1:0]   MODULUS_RESET = 32'd1048576;

    // Modulus used when the register holds zero (2^32)
    localparam logic [ADDR_W:0] MODULUS_FULL = 33'h1_0000_0000;

    // Last step of the bit-serial remainder unit
    localparam logic [OFFSET_W-1:0] REM_LAST = 5'd31;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,     // waiting for an address
        S_HSCAN,    // hit search, one frame a cycle
        S_BMOD,     // new page mod M
        S_DSCAN,    // fetch residue of one frame
        S_AMOD,     // frame page mod M
        S_DIST,     // clockwise distance
        S_DCMP,     // shorter way round, keep the best
        S_INSTALL,  // write the victim frame
        S_FIN       // hand the result to the output register
    } t_state;

endpackage

@@ rtl/longest_distance_page_replacement_unit.sv @@
`timescale 1ns / 1ps

// Longest-distance page replacement over FRAMES frames.
// Input channel (i_in_valid / o_in_ready) takes one virtual address per
// transfer; the output channel (o_out_valid / i_out_ready) returns one result
// per address: page number, hit flag, frame index and the evicted page.
// The config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 is
// the page offset width, index 1 the ring modulus (0 means 2^32).
// The frame store port reads one frame a cycle and the shared remainder
// unit works 1 bit per cycle. A hit ends the scan at the matching frame; a
// miss with an empty frame scans every frame and installs in one; a miss with
// all frames full reduces the page mod M when page >= M, weighs each frame's
// residue (computed if not cached and its page >= M; residues are cached per
// frame and dropped when the modulus is written) and distance, then installs.
// One address is worked on at a time; o_in_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and the
// next address is taken meanwhile, its own result waiting until the register
// frees. Reset empties every frame and restores the register defaults; no
// clearing pass is needed.
module longest_distance_page_replacement_unit #(
    parameter int FRAMES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // address channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ldpr_pkg::ADDR_W-1:0]        i_virt_address,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ldpr_pkg::ADDR_W-1:0]        o_page_number,
    output logic                               o_hit,
    output logic [ldpr_pkg::FRAME_OUT_W-1:0]   o_frame_index,
    output logic                               o_evicted_valid,
    output logic [ldpr_pkg::ADDR_W-1:0]        o_evicted_page,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ldpr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ldpr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int XW = (IW > ldpr_pkg::FRAME_OUT_W) ? IW : ldpr_pkg::FRAME_OUT_W;
    localparam int AW = ldpr_pkg::ADDR_W;

    // configuration
    logic [ldpr_pkg::OFFSET_W-1:0] r_offset;
    logic [AW-1:0]                 r_mod;

    // sequencer and datapath registers
    ldpr_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_page, n_page;
    logic             r_have_empty, n_have_empty;
    logic [IW-1:0]    r_empty_idx, n_empty_idx;
    logic [IW-1:0]    r_victim, n_victim;
    logic             r_hit, n_hit;
    logic             r_evv, n_evv;
    logic [AW-1:0]    r_evp, n_evp;
    logic [AW-1:0]    r_a, n_a;
    logic [AW-1:0]    r_b, n_b;
    logic [AW-1:0]    r_cw, n_cw;
    logic [AW-1:0]    r_best, n_best;
    // remainder unit
    logic [AW-1:0]                 r_dq, n_dq;
    logic [AW-1:0]                 r_rem, n_rem;
    logic [ldpr_pkg::OFFSET_W-1:0] r_cnt, n_cnt;

    // frame state
    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] r_res_ok;
    logic [AW-1:0]     m_page [FRAMES];
    logic [AW-1:0]     m_res  [FRAMES];
    logic [AW-1:0]     r_rd_page;
    logic [AW-1:0]     r_rd_res;

    // output register
    logic          r_out_valid;
    logic [AW-1:0] r_out_page;
    logic          r_out_hit;
    logic [XW-1:0] r_out_frame;
    logic          r_out_evv;
    logic [AW-1:0] r_out_evp;

    // shared combinational terms
    logic [AW:0]   w_m;
    logic          w_last;
    logic          w_match;
    logic          w_page_lt;
    logic          w_rd_lt;
    logic [AW:0]   w_rem_sh;
    logic [AW-1:0] w_rem_nx;
    logic [AW:0]   w_cw;
    logic [AW:0]   w_ccw;
    logic [AW-1:0] w_dist;
    logic          w_take;
    logic          w_cur_empty;
    logic          w_out_free;
    logic          w_res_we;
    logic [IW-1:0] w_res_addr;
    logic [AW-1:0] w_res_data;
    logic          w_mod_wr;

    assign o_in_ready  = (r_state == ldpr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_mod_wr    = i_cfg_valid && (i_cfg_index == ldpr_pkg::CFG_RING_MODULUS);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // modulus, zero read as 2^32
    assign w_m = (r_mod == '0) ? ldpr_pkg::MODULUS_FULL : {1'b0, r_mod};

    assign w_last      = (r_idx == IW'(FRAMES - 1));
    assign w_cur_empty = !r_valid[r_idx];
    assign w_match     = r_valid[r_idx] && (r_rd_page == r_page);
    assign w_page_lt   = ({1'b0, r_page} < w_m);
    assign w_rd_lt     = ({1'b0, r_rd_page} < w_m);

    // one restoring remainder step
    assign w_rem_sh = {r_rem, r_dq[AW-1]};
    assign w_rem_nx = (w_rem_sh >= w_m) ? AW'(w_rem_sh - w_m) : w_rem_sh[AW-1:0];

    // clockwise distance (a - b) mod M, both residues below M
    assign w_cw = (r_a >= r_b) ? ({1'b0, r_a} - {1'b0, r_b})
                               : ({1'b0, r_a} + w_m - {1'b0, r_b});
    // other way round and the shorter of the two
    assign w_ccw  = (r_cw == '0) ? '0 : (w_m - {1'b0, r_cw});
    assign w_dist = (r_cw < w_ccw[AW-1:0]) ? r_cw : w_ccw[AW-1:0];
    assign w_take = (r_idx == '0) || (w_dist > r_best);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ldpr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ldpr_pkg::S_HSCAN;
            end
            ldpr_pkg::S_HSCAN: begin
                if (w_match) begin
                    n_state = ldpr_pkg::S_FIN;
                end else if (w_last) begin
                    if (r_have_empty || w_cur_empty) n_state = ldpr_pkg::S_INSTALL;
                    else if (w_page_lt)              n_state = ldpr_pkg::S_DSCAN;
                    else                             n_state = ldpr_pkg::S_BMOD;
                end
            end
            ldpr_pkg::S_BMOD: begin
                if (r_cnt == ldpr_pkg::REM_LAST) n_state = ldpr_pkg::S_DSCAN;
            end
            ldpr_pkg::S_DSCAN: begin
                if (r_res_ok[r_idx] || w_rd_lt) n_state = ldpr_pkg::S_DIST;
                else                            n_state = ldpr_pkg::S_AMOD;
            end
            ldpr_pkg::S_AMOD: begin
                if (r_cnt == ldpr_pkg::REM_LAST) n_state = ldpr_pkg::S_DIST;
            end
            ldpr_pkg::S_DIST: begin
                n_state = ldpr_pkg::S_DCMP;
            end
            ldpr_pkg::S_DCMP: begin
                n_state = w_last ? ldpr_pkg::S_INSTALL : ldpr_pkg::S_DSCAN;
            end
            ldpr_pkg::S_INSTALL: begin
                n_state = ldpr_pkg::S_FIN;
            end
            ldpr_pkg::S_FIN: begin
                if (w_out_free) n_state = ldpr_pkg::S_IDLE;
            end
            default: n_state = ldpr_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_idx        = r_idx;
        n_page       = r_page;
        n_have_empty = r_have_empty;
        n_empty_idx  = r_empty_idx;
        n_victim     = r_victim;
        n_hit        = r_hit;
        n_evv        = r_evv;
        n_evp        = r_evp;
        n_a          = r_a;
        n_b          = r_b;
        n_cw         = r_cw;
        n_best       = r_best;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        w_res_we     = 1'b0;
        w_res_addr   = r_idx;
        w_res_data   = r_a;
        case (r_state)
            ldpr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_page       = i_virt_address >> r_offset;
                    n_idx        = '0;
                    n_have_empty = 1'b0;
                end
            end
            ldpr_pkg::S_HSCAN: begin
                if (w_match) begin
                    n_hit    = 1'b1;
                    n_victim = r_idx;
                    n_evv    = 1'b0;
                    n_evp    = '0;
                end else begin
                    if (w_cur_empty) begin
                        n_have_empty = 1'b1;
                        n_empty_idx  = r_idx;
                    end
                    if (w_last) begin
                        n_hit = 1'b0;
                        if (r_have_empty || w_cur_empty) begin
                            // last empty frame takes the page
                            n_victim = w_cur_empty ? r_idx : r_empty_idx;
                            n_idx    = w_cur_empty ? r_idx : r_empty_idx;
                        end else begin
                            n_idx = '0;
                            if (w_page_lt) begin
                                n_b = r_page;
                            end else begin
                                n_dq  = r_page;
                                n_rem = '0;
                                n_cnt = '0;
                            end
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ldpr_pkg::S_BMOD: begin
                n_dq  = r_dq << 1;
                n_rem = w_rem_nx;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ldpr_pkg::REM_LAST) n_b = w_rem_nx;
            end
            ldpr_pkg::S_DSCAN: begin
                if (r_res_ok[r_idx]) begin
                    n_a = r_rd_res;
                end else if (w_rd_lt) begin
                    n_a        = r_rd_page;
                    w_res_we   = 1'b1;
                    w_res_data = r_rd_page;
                end else begin
                    n_dq  = r_rd_page;
                    n_rem = '0;
                    n_cnt = '0;
                end
            end
            ldpr_pkg::S_AMOD: begin
                n_dq  = r_dq << 1;
                n_rem = w_rem_nx;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ldpr_pkg::REM_LAST) begin
                    n_a        = w_rem_nx;
                    w_res_we   = 1'b1;
                    w_res_data = w_rem_nx;
                end
            end
            ldpr_pkg::S_DIST: begin
                n_cw = w_cw[AW-1:0];
            end
            ldpr_pkg::S_DCMP: begin
                if (w_take) begin
                    n_best   = w_dist;
                    n_victim = r_idx;
                end
                if (w_last) n_idx = w_take ? r_idx : r_victim;
                else        n_idx = r_idx + 1'b1;
            end
            ldpr_pkg::S_INSTALL: begin
                n_evv      = r_valid[r_victim];
                n_evp      = r_valid[r_victim] ? r_rd_page : '0;
                w_res_we   = !r_have_empty;
                w_res_addr = r_victim;
                w_res_data = r_b;
            end
            ldpr_pkg::S_FIN: begin
                n_idx = '0;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ldpr_pkg::S_IDLE;
            r_offset    <= ldpr_pkg::OFFSET_RESET;
            r_mod       <= ldpr_pkg::MODULUS_RESET;
            r_valid     <= '0;
            r_res_ok    <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid && i_cfg_index == ldpr_pkg::CFG_OFFSET_BITS) begin
                r_offset <= i_cfg_data[ldpr_pkg::OFFSET_W-1:0];
            end
            if (w_mod_wr) begin
                r_mod <= i_cfg_data;
            end
            if (r_state == ldpr_pkg::S_INSTALL) begin
                r_valid[r_victim] <= 1'b1;
            end
            // cached residues go stale when the modulus changes
            if (w_mod_wr) begin
                r_res_ok <= '0;
            end else if (r_state == ldpr_pkg::S_INSTALL) begin
                r_res_ok[r_victim] <= !r_have_empty;
            end else if (w_res_we) begin
                r_res_ok[w_res_addr] <= 1'b1;
            end
            if (r_state == ldpr_pkg::S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_have_empty <= n_have_empty;
        r_empty_idx  <= n_empty_idx;
        r_victim     <= n_victim;
        r_hit        <= n_hit;
        r_evv        <= n_evv;
        r_evp        <= n_evp;
        r_a          <= n_a;
        r_b          <= n_b;
        r_cw         <= n_cw;
        r_best       <= n_best;
        r_dq         <= n_dq;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        if (r_state == ldpr_pkg::S_FIN && w_out_free) begin
            r_out_page  <= r_page;
            r_out_hit   <= r_hit;
            r_out_frame <= XW'(r_victim);
            r_out_evv   <= r_evv;
            r_out_evp   <= r_evp;
        end
    end

    // frame page store, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (r_state == ldpr_pkg::S_INSTALL) begin
            m_page[r_victim] <= r_page;
        end
        r_rd_page <= m_page[n_idx];
    end

    // residue store
    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            m_res[w_res_addr] <= w_res_data;
        end
        r_rd_res <= m_res[n_idx];
    end

    assign o_out_valid     = r_out_valid;
    assign o_page_number   = r_out_page;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_frame[ldpr_pkg::FRAME_OUT_W-1:0];
    assign o_evicted_valid = r_out_evv;
    assign o_evicted_page  = r_out_evp;

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted_valid && o_evicted_page == '0))
        else $error("hit result carries an eviction");

    // an accepted address leaves the input not ready in the cycle after
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second address taken while busy");

    // distance scan only runs with every frame occupied
    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldpr_pkg::S_DCMP) |-> (&r_valid))
        else $error("distance scan with an empty frame");

    // install leaves the victim frame occupied
    a_install_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldpr_pkg::S_INSTALL) |=> r_valid[$past(r_victim)])
        else $error("installed frame not marked valid");

    // the remainder unit finishes on its last step
    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldpr_pkg::S_AMOD && r_cnt == ldpr_pkg::REM_LAST)
        |=> (r_state == ldpr_pkg::S_DIST))
        else $error("remainder unit overran");

endmodule
